// File: rtl/mrtu_pkg.sv
// Shared types, constants and the CRC-16 byte update for the RTU frame builder.
`default_nettype none

package mrtu_pkg;

  localparam int unsigned FrameLen = 8;
  localparam int unsigned CrcBytes = 6;

  localparam logic [15:0] CrcInit = 16'hFFFF;
  localparam logic [15:0] CrcPoly = 16'hA001;

  localparam logic [7:0]  SlaveAddrReset = 8'd1;
  localparam logic [7:0]  FuncCodeReset  = 8'd6;
  localparam logic [15:0] RegAddrReset   = 16'd0;

  // Config register indexes.
  typedef enum logic [1:0] {
    CfgSlaveAddr = 2'd0,
    CfgFuncCode  = 2'd1,
    CfgRegAddr   = 2'd2
  } cfg_idx_t;

  // Item in flight: the six header/payload bytes (next CRC byte on top) and running CRC.
  typedef struct packed {
    logic [CrcBytes*8-1:0] frame;
    logic [15:0]           crc;
  } stage_t;

  // Reflected CRC-16 update over one byte, LSB first.
  function automatic logic [15:0] crc16_update(input logic [15:0] crc_in,
                                               input logic [7:0]  data);
    logic [15:0] c;
    c = crc_in ^ {8'h00, data};
    for (int b = 0; b < 8; b++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CrcPoly;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// File: rtl/mrtu_crc_stage.sv
// One CRC pipeline stage: folds the top frame byte into the CRC and rotates the frame.
`default_nettype none

module mrtu_crc_stage (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  input  wire mrtu_pkg::stage_t in_data,
  output logic                 in_ready,
  output logic                 out_valid,
  output mrtu_pkg::stage_t     out_data,
  input  wire logic            out_ready
);
  import mrtu_pkg::*;

  logic   valid;
  stage_t data;
  logic   load;

  assign in_ready  = !valid || out_ready;
  assign load      = in_valid && in_ready;
  assign out_valid = valid;
  assign out_data  = data;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  // Rotating by one byte per stage: after all stages the frame is back in order.
  always_ff @(posedge clk) begin
    if (load) begin
      data.crc   <= crc16_update(in_data.crc, in_data.frame[CrcBytes*8-1 -: 8]);
      data.frame <= {in_data.frame[CrcBytes*8-9:0], in_data.frame[CrcBytes*8-1 -: 8]};
    end
  end

endmodule

`default_nettype wire

// File: rtl/mrtu_serializer.sv
// Byte serializer: shifts out the eight frame bytes, one per cycle, header/payload first, then CRC high, CRC low.
`default_nettype none

module mrtu_serializer (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  input  wire mrtu_pkg::stage_t in_data,
  output logic                  in_ready,
  output logic                  strobe,
  output logic [7:0]            frame_byte,
  output logic                  last_byte
);
  import mrtu_pkg::*;

  localparam int unsigned CntW = $clog2(FrameLen);
  localparam logic [CntW-1:0] LastCnt = CntW'(FrameLen - 1);

  logic                  active;
  logic [CntW-1:0]       cnt;
  logic [FrameLen*8-1:0] shreg;
  logic                  at_last;

  assign at_last    = (cnt == LastCnt);
  assign in_ready   = !active || at_last;
  assign strobe     = active;
  assign frame_byte = shreg[FrameLen*8-1 -: 8];
  assign last_byte  = active && at_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      cnt    <= '0;
    end else if (in_ready) begin
      active <= in_valid;
      cnt    <= '0;
    end else begin
      cnt    <= cnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      shreg <= {in_data.frame, in_data.crc[15:8], in_data.crc[7:0]};
    end else if (active) begin
      shreg <= {shreg[FrameLen*8-9:0], 8'h00};
    end
  end

endmodule

`default_nettype wire

// File: rtl/modbus_rtu_write_frame_builder_top.sv
// Top level of the Modbus RTU write-single-register frame builder.
// Path: a transaction accepted on start passes the six CRC stages, then the byte serializer,
//   which sends its eight bytes consecutively.
// Throughput: set by the byte-wide output, which sends one frame at a time; the six
//   CRC stages buffer up to six more frames, so start may be taken back to back.
// Reset: synchronous rst empties the pipeline and loads slave address 1, function code 6,
//   register address 0. The receiver cannot stall; each byte shows for exactly one cycle.
`default_nettype none

module modbus_rtu_write_frame_builder_top (
  input  wire logic        clk,
  input  wire logic        rst,
  // config write port
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data,
  // command side
  input  wire logic        start,
  output logic             busy,
  input  wire logic [15:0] register_value,
  // result side
  output logic             strobe,
  output logic [7:0]       frame_byte,
  output logic             last_byte
);
  import mrtu_pkg::*;

  // Config registers. The user is to write them only while idle (not enforced), so frames
  // in flight see stable values; each transaction still captures its own header at entry.
  logic [7:0]  slave_address;
  logic [7:0]  function_code;
  logic [15:0] register_address;

  always_ff @(posedge clk) begin
    if (rst) begin
      slave_address    <= SlaveAddrReset;
      function_code    <= FuncCodeReset;
      register_address <= RegAddrReset;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CfgSlaveAddr: slave_address    <= cfg_data[7:0];
        CfgFuncCode:  function_code    <= cfg_data[7:0];
        CfgRegAddr:   register_address <= cfg_data;
        default:      ;  // unused index: write dropped
      endcase
    end
  end

  // Pipeline links: link[0] is the entry, link[CrcBytes] feeds the serializer.
  logic   link_valid [CrcBytes+1];
  logic   link_ready [CrcBytes+1];
  stage_t link_data  [CrcBytes+1];

  // Entry: frame bytes in transmit order, head byte on top, CRC preset.
  assign link_valid[0]      = start;
  assign link_data[0].frame = {slave_address, function_code, register_address,
                               register_value};
  assign link_data[0].crc   = CrcInit;

  // Busy only when the first CRC stage is full and cannot drain this cycle.
  assign busy = !link_ready[0];

  // One CRC stage per header/payload byte; 8 bit steps each.
  for (genvar s = 0; s < CrcBytes; s++) begin : g_crc
    mrtu_crc_stage u_stage (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (link_valid[s]),
      .in_data   (link_data[s]),
      .in_ready  (link_ready[s]),
      .out_valid (link_valid[s+1]),
      .out_data  (link_data[s+1]),
      .out_ready (link_ready[s+1])
    );
  end

  // Serializer takes a new frame when idle or while sending the last byte of the previous.
  mrtu_serializer u_ser (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (link_valid[CrcBytes]),
    .in_data    (link_data[CrcBytes]),
    .in_ready   (link_ready[CrcBytes]),
    .strobe     (strobe),
    .frame_byte (frame_byte),
    .last_byte  (last_byte)
  );

endmodule

`default_nettype wire
